// ===== hw/rtl/mpfb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes, types and helpers of the page-mode frame store blitter.
package mpfb_pkg;

   // Screen geometry and frame store layout.
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int BANK_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES   = SCREEN_WIDTH * BANK_COUNT;
   localparam int ADDR_W        = $clog2(STORE_BYTES);
   localparam int COL_W         = $clog2(SCREEN_WIDTH);
   localparam int BANK_W        = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

   // Rows of the last bank that lie on the screen.
   localparam int LAST_ROWS = SCREEN_HEIGHT - 8 * (BANK_COUNT - 1);
   localparam logic [7:0] LAST_BANK_MASK = 8'((9'd1 << LAST_ROWS) - 9'd1);

   // Sprite size limits.
   localparam int SPR_MAX_W = 128;
   localparam int SPR_MAX_H = 64;

   // Operation codes of a request.
   localparam logic [2:0] OP_SPRITE    = 3'd0;
   localparam logic [2:0] OP_CLEAR     = 3'd1;
   localparam logic [2:0] OP_SET_PIXEL = 3'd2;
   localparam logic [2:0] OP_GET_PIXEL = 3'd3;
   localparam logic [2:0] OP_GET_BYTE  = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] REG_BLIT_X           = 3'd0;
   localparam logic [2:0] REG_BLIT_Y           = 3'd1;
   localparam logic [2:0] REG_BLIT_W           = 3'd2;
   localparam logic [2:0] REG_BLIT_H           = 3'd3;
   localparam logic [2:0] REG_BLIT_COLOR       = 3'd4;
   localparam logic [2:0] REG_BLIT_TRANSPARENT = 3'd5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPRITE_LO,
      ST_SPRITE_HI,
      ST_PIXEL_SET,
      ST_PIXEL_GET,
      ST_BYTE_GET
   } seq_state_type;

   // Placement of the next sprite byte, prepared by the register block.
   typedef struct packed {
      logic [ADDR_W-1:0] addr0;
      logic [ADDR_W-1:0] addr1;
      logic [2:0]        shift;
      logic [7:0]        page_mask0;
      logic [7:0]        page_mask1;
      logic [7:0]        row_en;
      logic              color;
      logic              transparent;
      logic              done;
   } blit_plan_type;

   // One access to the frame memory.
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
   } mem_req_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } seq_status_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       pixel_value;
      logic       blit_done;
   } rsp_item_type;

   // Byte index of a column within a bank.
   function automatic logic [ADDR_W-1:0] frame_index(input logic [BANK_W-1:0] page,
                                                     input logic [COL_W-1:0]  col);
      frame_index = ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
   endfunction

endpackage

// ===== hw/rtl/mpfb_intf.sv =====
`timescale 1ns / 1ps
// Request, response and configuration channel interfaces of the blitter.
interface mpfb_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        op;
   logic [7:0]        sprite_byte;
   logic              draw_color;
   logic signed [8:0] px;
   logic signed [7:0] py;
   logic [9:0]        byte_addr;

   modport source (output valid, op, sprite_byte, draw_color, px, py, byte_addr,
                   input ready);
   modport sink (input valid, op, sprite_byte, draw_color, px, py, byte_addr,
                 output ready);
endinterface

interface mpfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       pixel_value;
   logic       blit_done;

   modport source (output valid, read_byte, pixel_value, blit_done, input ready);
   modport sink (input valid, read_byte, pixel_value, blit_done, output ready);
endinterface

interface mpfb_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] addr;
   logic [7:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

// ===== hw/rtl/mpfb_frame_ram.sv =====
`timescale 1ns / 1ps
// Frame store memory: one write port, one read port with registered read data.
module mpfb_frame_ram import mpfb_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_data_ff;

   // Synchronous write and read.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mpfb_blit_regs.sv =====
`timescale 1ns / 1ps
// Blit configuration registers, sprite position counters and byte placement.
module mpfb_blit_regs import mpfb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   mpfb_csr_if.sink      csr,
   input  logic          advance,
   output blit_plan_type plan
);

   logic signed [7:0] blit_x_ff, blit_x_in;
   logic signed [6:0] blit_y_ff, blit_y_in;
   logic [7:0]        blit_w_ff, blit_w_in;
   logic [6:0]        blit_h_ff, blit_h_in;
   logic              color_ff, color_in;
   logic              transp_ff, transp_in;
   logic [6:0]        col_ff, col_in;
   logic [2:0]        bank_ff, bank_in;

   logic              csr_fire;
   logic              reg_known;
   logic [7:0]        eff_w;
   logic [6:0]        eff_h;
   logic [3:0]        banks;
   logic              last_col;
   logic              last_bank;
   logic signed [9:0] dx;
   logic signed [8:0] ystart;
   logic signed [8:0] page0;
   logic signed [8:0] page1;
   logic              x_ok;
   logic              p0_ok;
   logic              p1_ok;

   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid && csr.ready;
   assign reg_known = (csr.addr <= REG_BLIT_TRANSPARENT);

   // Effective sprite size with out-of-range values clamped.
   always_comb begin
      if (blit_w_ff == 8'd0) begin
         eff_w = 8'd1;
      end else if (blit_w_ff > 8'(SPR_MAX_W)) begin
         eff_w = 8'(SPR_MAX_W);
      end else begin
         eff_w = blit_w_ff;
      end
      if (blit_h_ff == 7'd0) begin
         eff_h = 7'd1;
      end else if (blit_h_ff > 7'(SPR_MAX_H)) begin
         eff_h = 7'(SPR_MAX_H);
      end else begin
         eff_h = blit_h_ff;
      end
   end

   assign banks     = 4'((eff_h + 7'd7) >> 3);
   assign last_col  = ({1'b0, col_ff} + 8'd1) >= eff_w;
   assign last_bank = ({1'b0, bank_ff} + 4'd1) >= banks;

   // Register writes restart the sprite; each sprite byte steps the counters.
   always_comb begin
      blit_x_in = blit_x_ff;
      blit_y_in = blit_y_ff;
      blit_w_in = blit_w_ff;
      blit_h_in = blit_h_ff;
      color_in  = color_ff;
      transp_in = transp_ff;
      col_in    = col_ff;
      bank_in   = bank_ff;
      if (csr_fire && reg_known) begin
         unique case (csr.addr)
            REG_BLIT_X:           blit_x_in = csr.wdata;
            REG_BLIT_Y:           blit_y_in = csr.wdata[6:0];
            REG_BLIT_W:           blit_w_in = csr.wdata;
            REG_BLIT_H:           blit_h_in = csr.wdata[6:0];
            REG_BLIT_COLOR:       color_in  = csr.wdata[0];
            REG_BLIT_TRANSPARENT: transp_in = csr.wdata[0];
            default:              ;
         endcase
         col_in  = 7'd0;
         bank_in = 3'd0;
      end else if (advance) begin
         if (last_col) begin
            col_in  = 7'd0;
            bank_in = last_bank ? 3'd0 : bank_ff + 3'd1;
         end else begin
            col_in = col_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blit_x_ff <= 8'sd0;
         blit_y_ff <= 7'sd0;
         blit_w_ff <= 8'd1;
         blit_h_ff <= 7'd1;
         color_ff  <= 1'b1;
         transp_ff <= 1'b1;
         col_ff    <= 7'd0;
         bank_ff   <= 3'd0;
      end else begin
         blit_x_ff <= blit_x_in;
         blit_y_ff <= blit_y_in;
         blit_w_ff <= blit_w_in;
         blit_h_ff <= blit_h_in;
         color_ff  <= color_in;
         transp_ff <= transp_in;
         col_ff    <= col_in;
         bank_ff   <= bank_in;
      end
   end

   // Screen position of the current byte: one column, up to two banks.
   assign dx     = $signed({{2{blit_x_ff[7]}}, blit_x_ff}) + $signed({3'b000, col_ff});
   assign ystart = $signed({{2{blit_y_ff[6]}}, blit_y_ff}) + $signed({3'b000, bank_ff, 3'b000});
   assign page0  = ystart >>> 3;
   assign page1  = page0 + 9'sd1;
   assign x_ok   = (dx >= 0) && (dx < SCREEN_WIDTH);
   assign p0_ok  = (page0 >= 0) && (page0 < BANK_COUNT);
   assign p1_ok  = (page1 >= 0) && (page1 < BANK_COUNT);

   always_comb begin
      plan.addr0 = frame_index(BANK_W'(page0), COL_W'(dx));
      plan.addr1 = frame_index(BANK_W'(page1), COL_W'(dx));
      plan.shift = ystart[2:0];
      if (x_ok && p0_ok) begin
         plan.page_mask0 = (page0 == BANK_COUNT - 1) ? LAST_BANK_MASK : 8'hff;
      end else begin
         plan.page_mask0 = 8'h00;
      end
      if (x_ok && p1_ok) begin
         plan.page_mask1 = (page1 == BANK_COUNT - 1) ? LAST_BANK_MASK : 8'hff;
      end else begin
         plan.page_mask1 = 8'h00;
      end
      // Rows inside the sprite height; padding rows are ignored.
      for (int r = 0; r < 8; r++) begin
         plan.row_en[r] = (7'({bank_ff, 3'(r)}) < eff_h);
      end
      plan.color       = color_ff;
      plan.transparent = transp_ff;
      plan.done        = last_col && last_bank;
   end

endmodule

// ===== hw/rtl/mpfb_seq.sv =====
`timescale 1ns / 1ps
// Operation sequencer: read-modify-write of the frame store, clearing pass, result buffer.
module mpfb_seq import mpfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   mpfb_req_if.sink       req,
   mpfb_rsp_if.source     rsp,
   input  blit_plan_type  plan,
   output logic           advance,
   output mem_req_type    mem_req,
   input  logic [7:0]     rd_data,
   output seq_status_type status
);

   typedef struct packed {
      logic [ADDR_W-1:0] addr0;
      logic [ADDR_W-1:0] addr1;
      logic [7:0]        mask0;
      logic [7:0]        mask1;
      logic [7:0]        val0;
      logic [7:0]        val1;
      logic              done;
   } sprite_job_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [2:0]        bit_sel;
      logic              ok;
      logic              color;
      logic              byte_ok;
   } pixel_job_type;

   seq_state_type     state_ff, state_in;
   sprite_job_type    sjob_ff, sjob_in;
   pixel_job_type     pjob_ff, pjob_in;
   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic [7:0]        fill_ff, fill_in;
   logic              clear_reply_ff, clear_reply_in;
   rsp_item_type      out_ff, out_in;
   rsp_item_type      skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;

   logic              accept;
   logic              clear_last;
   logic              push;
   rsp_item_type      push_item;
   logic              pop;
   logic              px_ok;
   logic              py_ok;
   logic [ADDR_W-1:0] pix_addr;
   logic [7:0]        spr_on;
   logic [7:0]        spr_val;
   logic [15:0]       spr_mask16;
   logic [15:0]       spr_val16;
   logic [7:0]        bit_mask;

   assign req.ready  = (state_ff == ST_IDLE) && !skid_valid_ff;
   assign accept     = req.valid && req.ready;
   assign advance    = accept && (req.op == OP_SPRITE);
   assign clear_last = (clear_cnt_ff == ADDR_W'(STORE_BYTES - 1));

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.idle     = (state_ff == ST_IDLE);

   // Pixel address decode from the request.
   assign px_ok    = (req.px >= 0) && (req.px < SCREEN_WIDTH);
   assign py_ok    = (req.py >= 0) && (req.py < SCREEN_HEIGHT);
   assign pix_addr = frame_index(BANK_W'(req.py >>> 3), COL_W'(req.px));

   // Sprite byte split into the two banks it may touch.
   assign spr_on     = plan.row_en & (req.sprite_byte | {8{~plan.transparent}});
   assign spr_val    = plan.color ? req.sprite_byte : ~req.sprite_byte;
   assign spr_mask16 = {8'h00, spr_on} << plan.shift;
   assign spr_val16  = {8'h00, spr_val} << plan.shift;

   assign bit_mask = 8'h01 << pjob_ff.bit_sel;

   // Job registers loaded when a request is accepted.
   always_comb begin
      sjob_in        = sjob_ff;
      pjob_in        = pjob_ff;
      fill_in        = fill_ff;
      clear_reply_in = clear_reply_ff;
      if (accept) begin
         sjob_in.addr0    = plan.addr0;
         sjob_in.addr1    = plan.addr1;
         sjob_in.mask0    = spr_mask16[7:0] & plan.page_mask0;
         sjob_in.mask1    = spr_mask16[15:8] & plan.page_mask1;
         sjob_in.val0     = spr_val16[7:0];
         sjob_in.val1     = spr_val16[15:8];
         sjob_in.done     = plan.done;
         pjob_in.addr     = pix_addr;
         pjob_in.bit_sel  = req.py[2:0];
         pjob_in.ok       = px_ok && py_ok;
         pjob_in.color    = req.draw_color;
         pjob_in.byte_ok  = (32'(req.byte_addr) < STORE_BYTES);
         fill_in          = {8{req.draw_color}};
         clear_reply_in   = 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            state_in = clear_last ? ST_IDLE : ST_CLEAR;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req.op)
                  OP_SPRITE:    state_in = ST_SPRITE_LO;
                  OP_CLEAR:     state_in = ST_CLEAR;
                  OP_SET_PIXEL: state_in = ST_PIXEL_SET;
                  OP_GET_PIXEL: state_in = ST_PIXEL_GET;
                  OP_GET_BYTE:  state_in = ST_BYTE_GET;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_SPRITE_LO: begin
            state_in = (sjob_ff.mask1 != 8'h00) ? ST_SPRITE_HI : ST_IDLE;
         end
         ST_SPRITE_HI, ST_PIXEL_SET, ST_PIXEL_GET, ST_BYTE_GET: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory accesses and result push for each state.
   always_comb begin
      mem_req      = '0;
      push         = 1'b0;
      push_item    = '0;
      clear_cnt_in = clear_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clear_cnt_ff;
            mem_req.wr_data = fill_ff;
            clear_cnt_in    = clear_last ? '0 : clear_cnt_ff + 1'b1;
            push            = clear_last && clear_reply_ff;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req.op)
                  OP_SPRITE: begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = plan.addr0;
                  end
                  OP_CLEAR: ;
                  OP_SET_PIXEL, OP_GET_PIXEL: begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = pix_addr;
                  end
                  OP_GET_BYTE: begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = ADDR_W'(req.byte_addr);
                  end
                  default: push = 1'b1;
               endcase
            end
         end
         ST_SPRITE_LO: begin
            mem_req.wr_en   = (sjob_ff.mask0 != 8'h00);
            mem_req.wr_addr = sjob_ff.addr0;
            mem_req.wr_data = (rd_data & ~sjob_ff.mask0) | (sjob_ff.val0 & sjob_ff.mask0);
            if (sjob_ff.mask1 != 8'h00) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = sjob_ff.addr1;
            end else begin
               push                = 1'b1;
               push_item.blit_done = sjob_ff.done;
            end
         end
         ST_SPRITE_HI: begin
            mem_req.wr_en       = 1'b1;
            mem_req.wr_addr     = sjob_ff.addr1;
            mem_req.wr_data     = (rd_data & ~sjob_ff.mask1) | (sjob_ff.val1 & sjob_ff.mask1);
            push                = 1'b1;
            push_item.blit_done = sjob_ff.done;
         end
         ST_PIXEL_SET: begin
            mem_req.wr_en   = pjob_ff.ok;
            mem_req.wr_addr = pjob_ff.addr;
            mem_req.wr_data = pjob_ff.color ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
            push            = 1'b1;
         end
         ST_PIXEL_GET: begin
            push                  = 1'b1;
            push_item.pixel_value = pjob_ff.ok && rd_data[pjob_ff.bit_sel];
         end
         ST_BYTE_GET: begin
            push                = 1'b1;
            push_item.read_byte = pjob_ff.byte_ok ? rd_data : 8'h00;
         end
         default: ;
      endcase
   end

   // Two-entry result buffer: output register plus skid entry.
   assign pop = out_valid_ff && rsp.ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!out_valid_in) begin
            out_in       = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.read_byte   = out_ff.read_byte;
   assign rsp.pixel_value = out_ff.pixel_value;
   assign rsp.blit_done   = out_ff.blit_done;

   // Control registers; reset starts a zero-fill clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_cnt_ff   <= '0;
         fill_ff        <= 8'h00;
         clear_reply_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_cnt_ff   <= clear_cnt_in;
         fill_ff        <= fill_in;
         clear_reply_ff <= clear_reply_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sjob_ff <= sjob_in;
      pjob_ff <= pjob_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== hw/rtl/mono_page_framebuffer_blitter.sv =====
`timescale 1ns / 1ps
// Monochrome page-mode frame store with a streaming sprite blitter.
//
// Channels: req_bus carries one operation per request (sprite byte, clear, set pixel,
// read pixel, read byte); rsp_bus returns exactly one result per request, in order;
// csr_bus writes the blit registers (position, size, color, transparency) and is
// always ready. Any write to a known register restarts the sprite at its first byte.
// Steps: each frame byte that a sprite byte touches is read and written back, the first
// bank and then, when the byte straddles two banks, the second, because the frame memory has
// a single read port with registered read data. Set pixel, read pixel and read byte first
// read, then write or answer. A clear walks every byte of the store (STORE_BYTES, 1024),
// one per cycle. Unused op codes are answered from the idle state with no memory access.
// A result is pushed into the registered result buffer in the item's last working step.
// Reset: the store is cleared by a zero-fill pass, during which req_bus
// is not ready; csr_bus writes are taken throughout.
// Stall: results sit in a two-entry buffer, so the block accepts a new request while
// one result waits; req_bus ready is low while an item is being worked and while
// both entries are occupied.
module mono_page_framebuffer_blitter import mpfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mpfb_req_if.sink    req_bus,
   mpfb_rsp_if.source  rsp_bus,
   mpfb_csr_if.sink    csr_bus
);

   blit_plan_type  plan;
   logic           advance;
   mem_req_type    mem_req;
   logic [7:0]     rd_data;
   seq_status_type status;

   mpfb_blit_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_bus),
      .advance (advance),
      .plan    (plan)
   );

   mpfb_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .plan    (plan),
      .advance (advance),
      .mem_req (mem_req),
      .rd_data (rd_data),
      .status  (status)
   );

   mpfb_frame_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Reset always starts the clearing pass.
   a_reset_clears: assert property (@(posedge clock) reset |=> status.clearing)
      else $error("clearing pass did not start after reset");

   // No request is taken while the store is being cleared.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !(req_bus.valid && req_bus.ready))
      else $error("request accepted during clearing pass");

   // A read and a write in the same cycle never target the same byte.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("frame memory read and write collide");

   // The frame memory is written only outside the idle state: by an item or the clearing pass.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> !status.idle)
      else $error("frame memory written while idle");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the page-mode monochrome frame store blitter.
module testbench;
   import mpfb_pkg::*;

   localparam int CLOCK_PERIOD     = 12;
   localparam int CYCLE_LIMIT      = 900000;
   localparam int RANDOM_REQUESTS  = 1500;
   localparam int DRAIN_CYCLES     = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PRESSURE_PHASE   = 3;
   localparam int DIRECTED_ROWS    = 24;

   // Op codes that the block must answer with an all-zero result.
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0]        op;
      logic [7:0]        sprite_byte;
      logic              draw_color;
      logic signed [8:0] px;
      logic signed [7:0] py;
      logic [9:0]        byte_addr;
   } frame_request_type;

   typedef struct packed {
      frame_request_type req;
      logic              known;
      rsp_item_type      answer;
   } directed_row_type;

   logic clock;
   logic reset;

   mpfb_req_if req_bus();
   mpfb_rsp_if rsp_bus();
   mpfb_csr_if csr_bus();

   mono_page_framebuffer_blitter uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the frame store, the blit registers and the sprite position.
   logic [7:0]        shadow_frame [STORE_BYTES];
   logic signed [7:0] blit_left;
   logic signed [6:0] blit_top;
   logic [7:0]        blit_cols;
   logic [6:0]        blit_rows;
   logic              blit_ink;
   logic              blit_see_through;
   int                sprite_col_now;
   int                sprite_bank_now;

   rsp_item_type      readback_q [$];
   directed_row_type  directed_rows [DIRECTED_ROWS];
   int                error_count = 0;
   int                cycle_count = 0;
   bit                long_hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Pixel write into the shadow store, clipped to the screen.
   function automatic void plot(int x, int y, logic color);
      int idx;
      if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
      idx = (y / 8) * SCREEN_WIDTH + x;
      shadow_frame[idx][y % 8] = color;
   endfunction

   function automatic logic probe(int x, int y);
      if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return 1'b0;
      return shadow_frame[(y / 8) * SCREEN_WIDTH + x][y % 8];
   endfunction

   // Draws one sprite byte and steps the column/bank position; returns the done flag.
   function automatic logic sprite_advance(logic [7:0] data);
      int cols;
      int rows;
      int banks;
      int yy;
      int dx;
      logic done;
      cols = (blit_cols == 0) ? 1 : ((blit_cols > SPR_MAX_W) ? SPR_MAX_W : int'(blit_cols));
      rows = (blit_rows == 0) ? 1 : ((blit_rows > SPR_MAX_H) ? SPR_MAX_H : int'(blit_rows));
      banks = (rows + 7) / 8;
      done = 1'b0;
      dx = int'(blit_left) + sprite_col_now;
      for (int r = 0; r < 8; r++) begin
         yy = sprite_bank_now * 8 + r;
         if (yy < rows) begin
            if (data[r])
               plot(dx, int'(blit_top) + yy, blit_ink);
            else if (!blit_see_through)
               plot(dx, int'(blit_top) + yy, ~blit_ink);
         end
      end
      sprite_col_now++;
      if (sprite_col_now >= cols) begin
         sprite_col_now = 0;
         sprite_bank_now++;
         if (sprite_bank_now >= banks) begin
            sprite_bank_now = 0;
            done = 1'b1;
         end
      end
      return done;
   endfunction

   // Applies one request to the shadow store and returns the result it must produce.
   function automatic rsp_item_type apply_to_frame(frame_request_type rq);
      rsp_item_type res;
      res = '0;
      case (rq.op)
         OP_SPRITE: res.blit_done = sprite_advance(rq.sprite_byte);
         OP_CLEAR: foreach (shadow_frame[i]) shadow_frame[i] = {8{rq.draw_color}};
         OP_SET_PIXEL: plot(int'($signed(rq.px)), int'($signed(rq.py)), rq.draw_color);
         OP_GET_PIXEL: res.pixel_value = probe(int'($signed(rq.px)), int'($signed(rq.py)));
         OP_GET_BYTE: begin
            if (rq.byte_addr < STORE_BYTES) res.read_byte = shadow_frame[rq.byte_addr];
         end
         default: ;
      endcase
      return res;
   endfunction

   // Register write as seen by the shadow; unknown indexes change nothing.
   function automatic void set_register(logic [2:0] index, logic [7:0] data);
      case (index)
         REG_BLIT_X: blit_left = data;
         REG_BLIT_Y: blit_top = data[6:0];
         REG_BLIT_W: blit_cols = data;
         REG_BLIT_H: blit_rows = data[6:0];
         REG_BLIT_COLOR: blit_ink = data[0];
         REG_BLIT_TRANSPARENT: blit_see_through = data[0];
         default: return;
      endcase
      sprite_col_now = 0;
      sprite_bank_now = 0;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Random request, weighted toward sprite bytes and on-screen coordinates.
   function automatic frame_request_type make_request();
      frame_request_type rq;
      int pick;
      pick = $urandom_range(0, 999);
      rq.sprite_byte = 8'($urandom_range(0, 255));
      rq.draw_color = 1'($urandom_range(0, 1));
      rq.px = ($urandom_range(0, 3) != 0) ? 9'($urandom_range(0, SCREEN_WIDTH - 1))
                                          : 9'($urandom_range(0, 511));
      rq.py = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, SCREEN_HEIGHT - 1))
                                          : 8'($urandom_range(0, 255));
      rq.byte_addr = 10'($urandom_range(0, 1023));
      if (pick < 560)      rq.op = OP_SPRITE;
      else if (pick < 575) rq.op = OP_CLEAR;
      else if (pick < 700) rq.op = OP_SET_PIXEL;
      else if (pick < 840) rq.op = OP_GET_PIXEL;
      else if (pick < 970) rq.op = OP_GET_BYTE;
      else                 rq.op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      return rq;
   endfunction

   // Offers one request after a gap and records its expected result once taken.
   task automatic send_request(input frame_request_type rq, input logic known,
                               input rsp_item_type answer, input int gap);
      rsp_item_type predicted;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= rq.op;
      req_bus.sprite_byte <= rq.sprite_byte;
      req_bus.draw_color  <= rq.draw_color;
      req_bus.px          <= rq.px;
      req_bus.py          <= rq.py;
      req_bus.byte_addr   <= rq.byte_addr;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_to_frame(rq);
      readback_q.push_back(known ? answer : predicted);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [7:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= index;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      set_register(index, data);
   endtask

   task automatic program_blit(input int x, input int y, input int w, input int h,
                               input int color, input int transp);
      write_register(REG_BLIT_X, 8'(x));
      write_register(REG_BLIT_Y, 8'(y));
      write_register(REG_BLIT_W, 8'(w));
      write_register(REG_BLIT_H, 8'(h));
      write_register(REG_BLIT_COLOR, 8'(color));
      write_register(REG_BLIT_TRANSPARENT, 8'(transp));
   endtask

   // Stops offering requests and waits until every result is back and the block is quiet.
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      csr_bus.valid <= 1'b0;
      while (readback_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result receiver: random stalls, long ready stretches, and one long hold-off on request.
   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
            run_left = 0;
         end else if (stall_left == 0 && run_left == 0) begin
            stall_left = pick_gap();
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            run_left--;
         end
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (readback_q.size() == 0) begin
            $error("unexpected result: read_byte %0h pixel_value %0b blit_done %0b",
                   rsp_bus.read_byte, rsp_bus.pixel_value, rsp_bus.blit_done);
            error_count++;
         end else begin
            want = readback_q.pop_front();
            if (rsp_bus.read_byte !== want.read_byte) begin
               $error("read_byte: expected %0h, got %0h", want.read_byte, rsp_bus.read_byte);
               error_count++;
            end
            if (rsp_bus.pixel_value !== want.pixel_value) begin
               $error("pixel_value: expected %0b, got %0b",
                      want.pixel_value, rsp_bus.pixel_value);
               error_count++;
            end
            if (rsp_bus.blit_done !== want.blit_done) begin
               $error("blit_done: expected %0b, got %0b", want.blit_done, rsp_bus.blit_done);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int sent;
      int phase;
      int count;
      bit no_gaps;

      // Register reset values and an empty store.
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      blit_left = 0;
      blit_top = 0;
      blit_cols = 1;
      blit_rows = 1;
      blit_ink = 1'b1;
      blit_see_through = 1'b1;
      sprite_col_now = 0;
      sprite_bank_now = 0;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_SPRITE;
      req_bus.sprite_byte = '0;
      req_bus.draw_color = 1'b0;
      req_bus.px = '0;
      req_bus.py = '0;
      req_bus.byte_addr = '0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = REG_BLIT_X;
      csr_bus.wdata = '0;

      // Directed requests under the reset configuration: a 1x1 sprite in the top-left
      // corner, drawn in color 1 with transparency on. Coordinates 9'h100 and 8'h80 are
      // the most negative values, 9'h1FF is -1.
      directed_rows = '{
         '{'{OP_GET_BYTE, 8'h00, 1'b0, 9'd0, 8'd0, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_GET_BYTE, 8'h00, 1'b0, 9'd0, 8'd0, 10'd1023}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_GET_PIXEL, 8'h00, 1'b0, 9'd127, 8'd63, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_GET_PIXEL, 8'h00, 1'b0, 9'h100, 8'h80, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_GET_PIXEL, 8'h00, 1'b0, 9'd255, 8'd127, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_SPRITE, 8'hFF, 1'b0, 9'd0, 8'd0, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b1}},
         '{'{OP_GET_PIXEL, 8'h00, 1'b0, 9'd0, 8'd0, 10'd0}, 1'b0, '0},
         '{'{OP_GET_BYTE, 8'h00, 1'b0, 9'd0, 8'd0, 10'd0}, 1'b0, '0},
         '{'{OP_SET_PIXEL, 8'h00, 1'b1, 9'd127, 8'd63, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_SET_PIXEL, 8'h00, 1'b1, 9'h1FF, 8'd5, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_SET_PIXEL, 8'h00, 1'b1, 9'd255, 8'd127, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_GET_BYTE, 8'h00, 1'b0, 9'd0, 8'd0, 10'd1023}, 1'b0, '0},
         '{'{OP_SPARE_5, 8'hFF, 1'b1, 9'h1FF, 8'hFF, 10'h3FF}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_SPARE_6, 8'hFF, 1'b1, 9'd0, 8'd0, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_SPARE_7, 8'h00, 1'b0, 9'd3, 8'd3, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_CLEAR, 8'h00, 1'b1, 9'd0, 8'd0, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_GET_BYTE, 8'h00, 1'b0, 9'd0, 8'd0, 10'd512}, 1'b0, '0},
         '{'{OP_GET_PIXEL, 8'h00, 1'b0, 9'h100, 8'd0, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_SPRITE, 8'h00, 1'b0, 9'd0, 8'd0, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b1}},
         '{'{OP_CLEAR, 8'h00, 1'b0, 9'd0, 8'd0, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_SET_PIXEL, 8'h00, 1'b1, 9'd3, 8'd3, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_GET_PIXEL, 8'h00, 1'b0, 9'd3, 8'd3, 10'd0}, 1'b0, '0},
         '{'{OP_SET_PIXEL, 8'h00, 1'b0, 9'd3, 8'd3, 10'd0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
         '{'{OP_GET_BYTE, 8'h00, 1'b0, 9'd0, 8'd0, 10'd3}, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].known,
                      directed_rows[i].answer, pick_gap());
      settle();

      // Random phases: a new blit setting, then a burst of mixed requests.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (phase == PRESSURE_PHASE) long_hold_req = 1'b1;
         count = $urandom_range(30, 90);
         case (phase)
            0: program_blit(0, 0, 8, 8, 1, 0);
            1: program_blit(-128, -64, 255, 127, 0, 0);
            2: program_blit(127, 63, 0, 0, 1, 0);
            3: program_blit(-4, -3, 16, 8, 1, 1);
            4: program_blit(120, 60, 16, 12, 0, 1);
            5: program_blit(-3, -5, 1, 64, 1, 0);
            6: begin
               program_blit(0, 0, 128, 8, 0, 0);
               count = 260;
            end
            default: begin
               if ($urandom_range(0, 3) == 0)
                  write_register(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
               else
                  program_blit(
                     ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, 140)) - 12
                                                 : int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 72)) - 8 + int'($urandom_range(0, 1)) * 128,
                     ($urandom_range(0, 9) != 0) ? int'($urandom_range(1, 16))
                                                 : int'($urandom_range(0, 255)),
                     ($urandom_range(0, 9) != 0) ? int'($urandom_range(1, 24))
                                                 : int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)));
            end
         endcase
         @(negedge clock);
         csr_bus.valid <= 1'b0;

         no_gaps = (phase == PRESSURE_PHASE) || ($urandom_range(0, 4) == 0);
         repeat (count) begin
            send_request(make_request(), 1'b0, '0, no_gaps ? 0 : pick_gap());
            sent++;
         end
         settle();
         phase++;
      end

      if (error_count == 0 && readback_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
